// ===== design/rfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the register file ALU executor: instruction kinds,
// result status codes, sequencer states and the ALU request bundle.
// No dependencies.
package rfe_pkg;

    typedef enum logic [3:0] {
        K_ADD     = 4'd0,
        K_ADDI    = 4'd1,
        K_SUB     = 4'd2,
        K_MUL     = 4'd3,
        K_AND     = 4'd4,
        K_OR      = 4'd5,
        K_ORI     = 4'd6,
        K_XOR     = 4'd7,
        K_SLL     = 4'd8,
        K_SRL     = 4'd9,
        K_LI      = 4'd10,
        K_DUMP    = 4'd11,
        K_COMMENT = 4'd12,
        K_UNKNOWN = 4'd13,
        K_NEWPROG = 4'd14
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_LIMIT   = 2'd1,
        STAT_HALT    = 2'd2,
        STAT_HALTED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_EXEC,
        S_EMIT,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    typedef struct packed {
        kind_t       op;
        logic [31:0] a;
        logic [31:0] b;
        logic [4:0]  shamt;
    } alu_req_t;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 31;

endpackage

// ===== design/rfe_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rfe_alu.sv =====
`timescale 1ns / 1ps
// Shared ALU: add, sub, low multiply, logic ops, shifts, pass-through.
// Depends on rfe_pkg.
module rfe_alu (
    input  rfe_pkg::alu_req_t req,
    output logic [31:0]       y
);
    import rfe_pkg::*;

    always_comb
    begin
        case (req.op)
            K_ADD, K_ADDI: y = req.a + req.b;
            K_SUB:         y = req.a - req.b;
            K_MUL:         y = req.a * req.b;
            K_AND:         y = req.a & req.b;
            K_OR, K_ORI:   y = req.a | req.b;
            K_XOR:         y = req.a ^ req.b;
            K_SLL:         y = req.a << req.shamt;
            K_SRL:         y = req.a >> req.shamt;
            K_LI:          y = req.b;
            default:       y = '0;
        endcase
    end

endmodule

// ===== design/register_file_alu_executor.sv =====
`timescale 1ns / 1ps
// Register file ALU executor. An ALU item passes through states RD_B, EXEC and
// EMIT after its transfer before the next item is taken; ignored, halted,
// comment, unknown and new_program items go straight to EMIT; dump reads
// min(NUM_REGS,32) registers via the RAM read port, DUMP_RD then DUMP_OUT each.
// The output register frees the input once loaded; a stalled output holds
// the sequencer. Reset (rst_n low, async) clears control, valid bits (so the
// bank reads zero at once, no clearing pass), counter, halt flag, limit=max.
module register_file_alu_executor #(
    parameter int NUM_REGS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: instruction_limit
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] dest_reg, [9:5] src_a_reg, [14:10] src_b_reg, [46:15] immediate
    input  logic [47:0] s_tdata,
    // [3:0] kind
    input  logic [3:0]  s_tuser,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] reg_index, [36:5] reg_value, [67:37] executed_count
    output logic [71:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import rfe_pkg::*;

    localparam int AW        = $clog2(NUM_REGS);
    localparam int IW        = (AW > 5) ? AW : 5;
    localparam int DUMP_CNT  = (NUM_REGS < 32) ? NUM_REGS : 32;
    localparam logic [4:0] DUMP_LAST = 5'(DUMP_CNT - 1);

    // register index -> RAM address (indexes beyond the bank are gated off)
    function automatic logic [AW-1:0] to_addr(logic [4:0] idx);
        logic [IW-1:0] ext;
        ext = IW'(idx);
        return ext[AW-1:0];
    endfunction

    function automatic logic idx_ok(logic [4:0] idx);
        return (32'(idx) < NUM_REGS);
    endfunction

    // input field unpack
    kind_t       kind_in;
    logic [4:0]  dest_in;
    logic [4:0]  sa_in;
    logic [4:0]  sb_in;
    logic [31:0] imm_in;

    assign kind_in = kind_t'(s_tuser[3:0]);
    assign dest_in = s_tdata[4:0];
    assign sa_in   = s_tdata[9:5];
    assign sb_in   = s_tdata[14:10];
    assign imm_in  = s_tdata[46:15];

    // control state
    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    limit_reg;
    logic [COUNT_W-1:0]    item_count_reg, item_count_next;
    logic                  halted_reg, halted_next;
    logic [NUM_REGS-1:0]   valid_bits_reg, valid_bits_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic [4:0]            dump_idx_reg, dump_idx_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    kind_t                 kind_reg, kind_next;
    logic [4:0]            dest_idx_reg, dest_next;
    logic [4:0]            sb_reg, sb_next;
    logic [31:0]           imm_reg, imm_next;
    logic [31:0]           a_reg, a_next;
    status_t               res_status_reg, res_status_next;
    logic [4:0]            res_index_reg, res_index_next;
    logic [31:0]           res_value_reg, res_value_next;
    logic                  wr_pend_reg, wr_pend_next;
    status_t               out_status_reg, out_status_next;
    logic [4:0]            out_index_reg, out_index_next;
    logic [31:0]           out_value_reg, out_value_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                  out_last_reg, out_last_next;

    // RAM and ALU hookup
    logic [4:0]            rd_idx;
    logic [31:0]           rd_data;
    logic [31:0]           rd_val;
    logic                  ram_we;
    alu_req_t              alu_req;
    logic [31:0]           alu_y;
    logic                  out_free;
    logic                  s_xfer;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    // entries never written since reset or new_program read as zero
    assign rd_val   = rd_ok_reg ? rd_data : '0;

    rfe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_bank (
        .clk   (clk),
        .we    (ram_we),
        .waddr (to_addr(res_index_reg)),
        .wdata (res_value_reg),
        .raddr (to_addr(rd_idx)),
        .rdata (rd_data)
    );

    always_comb
    begin
        alu_req.op    = kind_reg;
        alu_req.a     = a_reg;
        alu_req.shamt = imm_reg[4:0];
        if (kind_reg == K_ADDI || kind_reg == K_ORI || kind_reg == K_LI)
        begin
            alu_req.b = imm_reg;
        end
        else
        begin
            alu_req.b = rd_val;
        end
    end

    rfe_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_count_next = item_count_reg;
        halted_next     = halted_reg;
        valid_bits_next = valid_bits_reg;
        dump_idx_next   = dump_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        kind_next       = kind_reg;
        dest_next       = dest_idx_reg;
        sb_next         = sb_reg;
        imm_next        = imm_reg;
        a_next          = a_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_value_next  = res_value_reg;
        wr_pend_next    = wr_pend_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        rd_idx          = dump_idx_reg;
        ram_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                rd_idx = sa_in;
                if (s_xfer)
                begin
                    kind_next       = kind_in;
                    dest_next       = dest_in;
                    sb_next         = sb_in;
                    imm_next        = imm_in;
                    res_status_next = STAT_OK;
                    res_index_next  = dest_in;
                    res_value_next  = '0;
                    wr_pend_next    = 1'b0;
                    state_next      = S_EMIT;
                    if (kind_in == K_NEWPROG)
                    begin
                        item_count_next = '0;
                        halted_next     = 1'b0;
                        valid_bits_next = '0;
                        res_index_next  = '0;
                    end
                    else if (halted_reg)
                    begin
                        res_status_next = STAT_HALTED;
                    end
                    else if (item_count_reg >= limit_reg)
                    begin
                        res_status_next = STAT_LIMIT;
                    end
                    else
                    begin
                        item_count_next = item_count_reg + 1'b1;
                        case (kind_in)
                            K_ADD, K_ADDI, K_SUB, K_MUL, K_AND, K_OR, K_ORI,
                            K_XOR, K_SLL, K_SRL, K_LI:
                            begin
                                // source A read issued this cycle
                                state_next = S_RD_B;
                            end
                            K_DUMP:
                            begin
                                dump_idx_next = '0;
                                state_next    = S_DUMP_RD;
                            end
                            K_COMMENT:
                            begin
                                res_index_next = '0;
                            end
                            default:
                            begin
                                // unknown kind: halt until new_program
                                halted_next     = 1'b1;
                                res_status_next = STAT_HALT;
                            end
                        endcase
                    end
                end
            end
            S_RD_A:
            begin
                rd_idx     = dest_idx_reg;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                rd_idx     = sb_reg;
                a_next     = rd_val;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                rd_idx          = sb_reg;
                res_value_next  = alu_y;
                res_index_next  = dest_idx_reg;
                res_status_next = STAT_OK;
                wr_pend_next    = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ram_we          = wr_pend_reg && idx_ok(res_index_reg);
                    if (ram_we)
                    begin
                        valid_bits_next[to_addr(res_index_reg)] = 1'b1;
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    out_value_next  = res_value_reg;
                    out_count_next  = item_count_reg;
                    out_last_next   = 1'b1;
                    wr_pend_next    = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                // address held so read data stays put while the output stalls
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_index_next  = dump_idx_reg;
                    out_value_next  = rd_val;
                    out_count_next  = item_count_reg;
                    out_last_next   = (dump_idx_reg == DUMP_LAST);
                    if (dump_idx_reg == DUMP_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dump_idx_next = dump_idx_reg + 1'b1;
                        state_next    = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_ok_next = idx_ok(rd_idx) && valid_bits_reg[to_addr(rd_idx)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            limit_reg      <= '1;
            item_count_reg <= '0;
            halted_reg     <= 1'b0;
            valid_bits_reg <= '0;
            rd_ok_reg      <= 1'b0;
            dump_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            wr_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            item_count_reg <= item_count_next;
            halted_reg     <= halted_next;
            valid_bits_reg <= valid_bits_next;
            rd_ok_reg      <= rd_ok_next;
            dump_idx_reg   <= dump_idx_next;
            out_valid_reg  <= out_valid_next;
            wr_pend_reg    <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        dest_idx_reg   <= dest_next;
        sb_reg         <= sb_next;
        imm_reg        <= imm_next;
        a_reg          <= a_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_value_reg, out_index_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // new_program wipes bank, counter and halt flag in one step
    a_newprog_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && kind_in == K_NEWPROG) |=>
            (item_count_reg == '0 && !halted_reg && valid_bits_reg == '0))
        else $error("new_program did not clear state");

    // a halted item leaves the counter alone
    a_halted_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && halted_reg && kind_in != K_NEWPROG) |=> $stable(item_count_reg))
        else $error("counter moved while halted");

    // bank writes only as the result is loaded into the output register
    a_write_with_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EMIT && out_free))
        else $error("bank write outside result load");

    // a non-final dump transfer goes back for the next register
    a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP_OUT && out_free && dump_idx_reg != DUMP_LAST) |=>
            (state_reg == S_DUMP_RD))
        else $error("dump ended early");
`endif

endmodule

// ===== dv/register_file_alu_executor_checker.sv =====
`timescale 1ns / 1ps
// Checker for the register file ALU executor: watches the config, input and
// output channels, keeps a shadow register bank and compares each result.
// Depends on rfe_pkg.
module register_file_alu_executor_checker #(
    parameter int NUM_REGS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending
);
    import rfe_pkg::*;

    localparam int DUMP_LEN = (NUM_REGS < 32) ? NUM_REGS : 32;

    typedef struct {
        status_t     status;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [30:0] exec_count;
        logic        last;
    } exec_result_t;

    logic [31:0]  shadow_bank [NUM_REGS];
    logic [30:0]  shadow_count;
    logic         shadow_halted;
    logic [30:0]  shadow_limit;
    exec_result_t expected_results [$];

    task automatic queue_result(input status_t st, input logic [4:0] idx,
                                input logic [31:0] val, input logic last);
        exec_result_t r;
        r.status     = st;
        r.reg_index  = idx;
        r.reg_value  = val;
        r.exec_count = shadow_count;
        r.last       = last;
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic logic [31:0] read_reg(input logic [4:0] idx);
        return (int'(idx) < NUM_REGS) ? shadow_bank[idx] : 32'd0;
    endfunction

    task automatic clear_bank();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            shadow_bank[i] = 32'd0;
        end
    endtask

    task automatic execute_instruction(input logic [3:0] kind, input logic [4:0] dest,
                                       input logic [4:0] src_a, input logic [4:0] src_b,
                                       input logic [31:0] imm);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] v;
        logic        writes;
        a      = read_reg(src_a);
        b      = read_reg(src_b);
        v      = 32'd0;
        writes = 1'b1;
        if (kind == K_NEWPROG)
        begin
            clear_bank();
            shadow_count  = '0;
            shadow_halted = 1'b0;
            queue_result(STAT_OK, 5'd0, 32'd0, 1'b1);
        end
        else if (shadow_halted)
        begin
            queue_result(STAT_HALTED, dest, 32'd0, 1'b1);
        end
        else if (shadow_count >= shadow_limit)
        begin
            queue_result(STAT_LIMIT, dest, 32'd0, 1'b1);
        end
        else
        begin
            shadow_count = shadow_count + 31'd1;
            case (kind)
                K_ADD:   v = a + b;
                K_ADDI:  v = a + imm;
                K_SUB:   v = a - b;
                K_MUL:   v = a * b;
                K_AND:   v = a & b;
                K_OR:    v = a | b;
                K_ORI:   v = a | imm;
                K_XOR:   v = a ^ b;
                K_SLL:   v = a << imm[4:0];
                K_SRL:   v = a >> imm[4:0];
                K_LI:    v = imm;
                default: writes = 1'b0;
            endcase
            if (writes)
            begin
                if (int'(dest) < NUM_REGS)
                begin
                    shadow_bank[dest] = v;
                end
                queue_result(STAT_OK, dest, v, 1'b1);
            end
            else if (kind == K_DUMP)
            begin
                for (int i = 0; i < DUMP_LEN; i++)
                begin
                    queue_result(STAT_OK, 5'(i), shadow_bank[i], i == DUMP_LEN - 1);
                end
            end
            else if (kind == K_COMMENT)
            begin
                queue_result(STAT_OK, 5'd0, 32'd0, 1'b1);
            end
            else
            begin
                // unknown kind, counted: halts until a new program
                shadow_halted = 1'b1;
                queue_result(STAT_HALT, dest, 32'd0, 1'b1);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    task automatic check_result();
        exec_result_t e;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual tdata %h tuser %h last %b",
                     $time, m_tdata, m_tuser, m_tlast);
            mismatches++;
        end
        else
        begin
            e = expected_results.pop_front();
            compare_field("status", 32'(e.status), 32'(m_tuser));
            compare_field("reg_index", 32'(e.reg_index), 32'(m_tdata[4:0]));
            compare_field("reg_value", e.reg_value, m_tdata[36:5]);
            compare_field("executed_count", 32'(e.exec_count), 32'(m_tdata[67:37]));
            compare_field("last", 32'(e.last), 32'(m_tlast));
        end
    endtask

    // output transfer is checked first: it can never belong to an item
    // accepted at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_bank();
            shadow_count  = '0;
            shadow_halted = 1'b0;
            shadow_limit  = 31'h7FFF_FFFF;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (cfg_we)
            begin
                shadow_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                execute_instruction(s_tuser, s_tdata[4:0], s_tdata[9:5], s_tdata[14:10],
                                    s_tdata[46:15]);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== dv/register_file_alu_executor_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the register file ALU executor: drives directed and random
// instruction streams, sets the limit between phases, and gives the verdict.
// Depends on rfe_pkg, register_file_alu_executor and its checker.
module register_file_alu_executor_tb;
    import rfe_pkg::*;

    localparam int          NUM_REGS     = 32;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [3:0]  KIND_SPARE   = 4'd15;    // second unknown encoding
    localparam logic [30:0] LIMIT_MAX    = 31'h7FFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [30:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [4:0] dest_reg, [9:5] src_a_reg, [14:10] src_b_reg, [46:15] immediate
    logic [47:0] s_tdata = '0;
    // [3:0] kind
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [4:0] reg_index, [36:5] reg_value, [67:37] executed_count
    logic [71:0] m_tdata;
    // [1:0] status
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int mismatches;
    int pending;
    int cycle_count = 0;

    // idle percentages per phase; recv side read by the receiver process
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off, armed once by the stimulus
    logic hold_armed = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    // rough guess whether the block is halted, to steer toward new_program
    logic likely_halted = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    register_file_alu_executor #(
        .NUM_REGS (NUM_REGS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    register_file_alu_executor_checker #(
        .NUM_REGS (NUM_REGS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Receiver: random backpressure, plus one long hold-off. During the hold
    // the sender keeps offering, so the output register and the sequencer
    // fill and s_tready drops.
    always @(negedge clk)
    begin
        if (hold_armed && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: generous bound over the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("register_file_alu_executor regression: fail");
            $finish;
        end
    end

    // One input transfer. Called at a falling edge and returns at the falling
    // edge after the transfer; the next call must drive in that same step so
    // the held item is never taken twice.
    task automatic send_item(input logic [3:0] kind, input logic [4:0] dest,
                             input logic [4:0] src_a, input logic [4:0] src_b,
                             input logic [31:0] imm);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, imm, src_b, src_a, dest};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    // Let every expected result come out, then write the limit while idle.
    task automatic set_limit(input logic [30:0] limit);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        repeat (4) @(negedge clk);    // sequencer back to idle after the last transfer
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed programs: ALU ops and loads with random registers,
    // occasional dumps, comments, halts and restarts, plus some raw noise.
    task automatic random_item();
        int          pick;
        logic [3:0]  kind;
        logic [31:0] imm;
        pick = $urandom_range(0, 99);
        if (likely_halted && pick < 30)
            kind = K_NEWPROG;
        else if (pick < 60)
            kind = 4'($urandom_range(K_ADD, K_SRL));
        else if (pick < 78)
            kind = K_LI;
        else if (pick < 82)
            kind = K_DUMP;
        else if (pick < 86)
            kind = K_COMMENT;
        else if (pick < 89)
            kind = ($urandom_range(0, 1) != 0) ? K_UNKNOWN : KIND_SPARE;
        else if (pick < 93)
            kind = K_NEWPROG;
        else
            kind = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0:       imm = 32'h0000_0000;
            1:       imm = 32'h7FFF_FFFF;
            2:       imm = 32'h8000_0000;
            3:       imm = 32'hFFFF_FFFF;
            default: imm = $urandom;
        endcase
        if (kind == K_UNKNOWN || kind == KIND_SPARE)
            likely_halted = 1'b1;
        else if (kind == K_NEWPROG)
            likely_halted = 1'b0;
        send_item(kind, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  5'($urandom_range(0, 31)), imm);
    endtask

    initial
    begin
        send_idle_pct = 25;
        recv_idle_pct <= 54;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: operand extremes, wrap-around, every operation, reg 0 writable
        send_item(K_LI,      5'd1,  5'd0,  5'd0,  32'h7FFF_FFFF);
        send_item(K_LI,      5'd2,  5'd0,  5'd0,  32'h8000_0000);
        send_item(K_LI,      5'd31, 5'd0,  5'd0,  32'hFFFF_FFFF);
        send_item(K_ADD,     5'd3,  5'd1,  5'd1,  32'd0);
        send_item(K_ADDI,    5'd4,  5'd31, 5'd0,  32'h0000_0001);
        send_item(K_SUB,     5'd5,  5'd1,  5'd2,  32'd0);
        send_item(K_MUL,     5'd6,  5'd1,  5'd31, 32'd0);
        send_item(K_AND,     5'd7,  5'd31, 5'd2,  32'd0);
        send_item(K_OR,      5'd8,  5'd1,  5'd2,  32'd0);
        send_item(K_ORI,     5'd9,  5'd0,  5'd0,  32'h8000_0000);
        send_item(K_XOR,     5'd10, 5'd31, 5'd1,  32'd0);
        // shift amounts use only the low five bits of the immediate
        send_item(K_SLL,     5'd11, 5'd31, 5'd0,  32'hFFFF_FFE1);
        send_item(K_SLL,     5'd12, 5'd1,  5'd0,  32'd31);
        send_item(K_SRL,     5'd13, 5'd2,  5'd0,  32'd31);
        send_item(K_SRL,     5'd14, 5'd31, 5'd0,  32'd32);
        send_item(K_LI,      5'd0,  5'd0,  5'd0,  32'h1234_5678);
        send_item(K_COMMENT, 5'd7,  5'd3,  5'd4,  32'hDEAD_BEEF);
        send_item(K_DUMP,    5'd0,  5'd0,  5'd0,  32'd0);
        // unknown halts; halted items report status only, then a restart
        send_item(K_UNKNOWN, 5'd21, 5'd0,  5'd0,  32'd0);
        send_item(K_ADD,     5'd22, 5'd1,  5'd2,  32'd0);
        send_item(K_DUMP,    5'd23, 5'd0,  5'd0,  32'd0);
        send_item(K_NEWPROG, 5'd24, 5'd1,  5'd1,  32'hFFFF_FFFF);
        send_item(KIND_SPARE, 5'd25, 5'd0, 5'd0,  32'd0);
        send_item(K_NEWPROG, 5'd0,  5'd0,  5'd0,  32'd0);

        // Limit of zero: everything but new_program is ignored, unknown does not halt
        set_limit(31'd0);
        send_item(K_ADD,     5'd3,  5'd1,  5'd2,  32'd0);
        send_item(K_UNKNOWN, 5'd4,  5'd0,  5'd0,  32'd0);
        send_item(K_DUMP,    5'd5,  5'd0,  5'd0,  32'd0);
        send_item(K_NEWPROG, 5'd0,  5'd0,  5'd0,  32'd0);

        // Limit of three: third item counted, fourth ignored
        set_limit(31'd3);
        send_item(K_LI,      5'd5,  5'd0,  5'd0,  32'h0000_00A5);
        send_item(K_LI,      5'd6,  5'd0,  5'd0,  32'h5A00_0000);
        send_item(K_DUMP,    5'd0,  5'd0,  5'd0,  32'd0);
        send_item(K_ADD,     5'd7,  5'd5,  5'd6,  32'd0);
        send_item(K_NEWPROG, 5'd0,  5'd0,  5'd0,  32'd0);

        // Phase A: sender idles lightly, receiver heavily, unlimited count
        set_limit(LIMIT_MAX);
        likely_halted = 1'b0;
        repeat (100) random_item();

        // Phase B: the other way round, small limit so restarts matter
        send_idle_pct = 54;
        recv_idle_pct <= 25;
        set_limit(31'($urandom_range(8, 40)));
        repeat (100) random_item();

        // Phase C: no idling, one long receiver hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        set_limit(31'($urandom_range(60, 400)));
        hold_armed <= 1'b1;
        repeat (50) random_item();

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (80) @(posedge clk);    // catch any stray result after the last dump
        if (mismatches == 0 && pending == 0)
            $display("register_file_alu_executor regression: pass");
        else
            $display("register_file_alu_executor regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rfe_pkg.sv
design/rfe_ram.sv
design/rfe_alu.sv
design/register_file_alu_executor.sv
dv/register_file_alu_executor_checker.sv
dv/register_file_alu_executor_tb.sv
